// ===== hw/rtl/ct3_pkg.sv =====
// Shared constants and types for the 3x3 census transform.
package ct3_pkg;

    // Pixel and configuration field widths
    localparam int PIXEL_W       = 8;
    localparam int CODE_W        = 8;
    localparam int CFG_WIDTH_W   = 12;
    localparam int CFG_HEIGHT_W  = 13;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_IDX_W     = 2;

    // Frame size limits and reset values
    localparam int MAX_WIDTH_DEF    = 2048;
    localparam int MAX_HEIGHT_DEF   = 4096;
    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;
    localparam int MIN_DIM          = 3;

    // One line store word holds the upper and the lower line at one column
    localparam int LINE_WORD_W = 2 * PIXEL_W;

    // Result queue depth; a power of two
    localparam int OUT_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } ct3_reg_t;

endpackage

// ===== hw/rtl/ct3_if.sv =====
// Handshake channels for pixel words and census result words.
interface ct3_pixel_if
    import ct3_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface ct3_code_if
    import ct3_pkg::*;
#(
    parameter int ROW_W = $clog2(MAX_HEIGHT_DEF),
    parameter int COL_W = $clog2(MAX_WIDTH_DEF)
);
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code;
    logic [ROW_W-1:0]  out_row;
    logic [COL_W-1:0]  out_col;
    logic              is_border;
    logic              frame_done;
    logic              last_of_run;

    modport source (
        output valid, output code, output out_row, output out_col,
        output is_border, output frame_done, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input code, input out_row, input out_col,
        input is_border, input frame_done, input last_of_run,
        output ready
    );
endinterface

// ===== hw/rtl/ct3_line_store.sv =====
// Dual line store: one word per column holding the two previous rows.
module ct3_line_store
    import ct3_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [LINE_WORD_W-1:0]   wr_data,
    output logic [LINE_WORD_W-1:0]   rd_data
);

    logic [LINE_WORD_W-1:0] mem [DEPTH];
    logic [LINE_WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold the read word while the pipeline stalls
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/ct3_window.sv =====
// 3x3 pixel window and the census compare against its centre.
module ct3_window
    import ct3_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift_en,
    input  logic [PIXEL_W-1:0] up,
    input  logic [PIXEL_W-1:0] lo,
    input  logic [PIXEL_W-1:0] px,
    output logic [CODE_W-1:0]  code
);

    // Neighbour positions in the window, NW first, SE last; centre is 4
    localparam int NB_IDX [CODE_W] = '{0, 1, 2, 3, 5, 6, 7, 8};
    localparam int CENTRE = 4;

    logic [PIXEL_W-1:0] win_reg [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (shift_en)
        begin
            // advance each row one column west, new column enters east
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r * 3 + 0] <= win_reg[r * 3 + 1];
                win_reg[r * 3 + 1] <= win_reg[r * 3 + 2];
            end
            win_reg[2] <= up;
            win_reg[5] <= lo;
            win_reg[8] <= px;
        end
    end

    always_comb
    begin
        for (int i = 0; i < CODE_W; i++)
        begin
            code[i] = (win_reg[NB_IDX[i]] >= win_reg[CENTRE]);
        end
    end

endmodule

// ===== hw/rtl/ct3_out_fifo.sv =====
// Result queue taking up to two words a cycle and giving one.
module ct3_out_fifo
    import ct3_pkg::*;
#(
    parameter int DATA_W = 36
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_a,
    input  logic [DATA_W-1:0] data_a,
    input  logic              push_b,
    input  logic [DATA_W-1:0] data_b,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    logic [DATA_W-1:0] mem [OUT_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  addr_b;
    logic              pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    // space for two words regardless of this cycle's pop
    assign room      = (count_reg <= CNT_W'(OUT_DEPTH - 2));
    assign addr_b    = push_a ? (wr_ptr_reg + PTR_W'(1)) : wr_ptr_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_a) + PTR_W'(push_b);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_a) + CNT_W'(push_b) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            mem[wr_ptr_reg] <= data_a;
        end
        if (push_b)
        begin
            mem[addr_b] <= data_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push_a || push_b) |-> (count_reg <= CNT_W'(OUT_DEPTH - 2)))
        else $error("result queue written without room");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(OUT_DEPTH))
        else $error("result queue count beyond depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

// ===== hw/rtl/census_transform_3x3.sv =====
// Top level of the 3x3 census transform over a raster pixel stream.
//
// Pixels enter one per clock in raster order, frame after frame, whenever
// the result queue has room, and every accepted pixel moves through a line
// store read stage and a window stage into a four-word result queue, so
// the block sustains one pixel per cycle while the queue has room. Results
// trail the input by one row and one column: the pixel at (r, c) with r and
// c both non-zero yields the code of (r-1, c-1), and the last pixel of a row
// also yields the zero code of the right border pixel above it, so a row of
// W pixels gives W result words; the queue absorbs that pair and the empty
// first column evens it out. The bottom border row is never sent. Border
// pixels carry code 0 and is_border set. The line store is one memory with
// one read and one write port, read at the pixel's column and written from
// the read stage; both ports set the rate of one pixel per clock. Writing
// frame_width or frame_height restarts the frame at row 0, column 0; write
// them only while the block is idle. Values are clamped to 3 .. MAX_WIDTH
// and 3 .. MAX_HEIGHT. No clearing pass follows reset.
module census_transform_3x3
    import ct3_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    ct3_pixel_if.sink             pixels,
    ct3_code_if.source            codes
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
    localparam int RST_WIDTH  = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
    localparam int RST_HEIGHT = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT
                                                                : FRAME_HEIGHT_RST;

    typedef struct packed {
        logic emit_a;
        logic emit_b;
        logic interior;
        logic last_col;
        logic last_row;
    } flags_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [ROW_W-1:0]  out_row;
        logic [COL_W-1:0]  out_col;
        logic              is_border;
        logic              frame_done;
        logic              last_of_run;
    } result_t;

    // configuration
    logic [WID_W-1:0]        width_reg, width_next;
    logic [HGT_W-1:0]        height_reg, height_next;
    logic [CFG_WIDTH_W-1:0]  cfg_w_val;
    logic [CFG_HEIGHT_W-1:0] cfg_h_val;
    logic                    cfg_hit_w, cfg_hit_h, cfg_hit;

    // raster position
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             last_col, last_row;
    flags_t           flags_in;

    // pipeline
    logic               advance, accept;
    logic               s1_valid_reg, s2_valid_reg;
    logic [PIXEL_W-1:0] s1_px_reg;
    logic [COL_W-1:0]   s1_col_reg, s2_col_reg;
    logic [ROW_W-1:0]   s1_row_reg, s2_row_reg;
    flags_t             s1_flags_reg, s2_flags_reg;

    logic [LINE_WORD_W-1:0] line_rd;
    logic [PIXEL_W-1:0]     line_up, line_lo;
    logic [CODE_W-1:0]      census;

    result_t res_a, res_b, res_out;
    logic    push_a, push_b, room;

    // ---------------- configuration ----------------
    assign cfg_w_val = cfg_wdata[CFG_WIDTH_W-1:0];
    assign cfg_h_val = cfg_wdata[CFG_HEIGHT_W-1:0];
    assign cfg_hit_w = cfg_wr_en && (cfg_index == REG_FRAME_WIDTH);
    assign cfg_hit_h = cfg_wr_en && (cfg_index == REG_FRAME_HEIGHT);
    assign cfg_hit   = cfg_hit_w || cfg_hit_h;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_hit_w)
        begin
            if (cfg_w_val < CFG_WIDTH_W'(MIN_DIM))
            begin
                width_next = WID_W'(MIN_DIM);
            end
            else if (32'(cfg_w_val) > 32'(MAX_WIDTH))
            begin
                width_next = WID_W'(MAX_WIDTH);
            end
            else
            begin
                width_next = WID_W'(cfg_w_val);
            end
        end
        if (cfg_hit_h)
        begin
            if (cfg_h_val < CFG_HEIGHT_W'(MIN_DIM))
            begin
                height_next = HGT_W'(MIN_DIM);
            end
            else if (32'(cfg_h_val) > 32'(MAX_HEIGHT))
            begin
                height_next = HGT_W'(MAX_HEIGHT);
            end
            else
            begin
                height_next = HGT_W'(cfg_h_val);
            end
        end
    end

    // ---------------- raster counters ----------------
    assign advance      = room;
    assign pixels.ready = advance;
    assign accept       = pixels.valid && advance;

    assign last_col = ((COL_W + 1)'(col_reg) + (COL_W + 1)'(1)) == (COL_W + 1)'(width_reg);
    assign last_row = ((ROW_W + 1)'(row_reg) + (ROW_W + 1)'(1)) == (ROW_W + 1)'(height_reg);

    always_comb
    begin
        flags_in.emit_a   = (row_reg != '0) && (col_reg != '0);
        flags_in.emit_b   = (row_reg != '0) && last_col;
        flags_in.interior = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
        flags_in.last_col = last_col;
        flags_in.last_row = last_row;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : (row_reg + ROW_W'(1));
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WID_W'(RST_WIDTH);
            height_reg <= HGT_W'(RST_HEIGHT);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    // ---------------- pipeline stages ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg    <= pixels.pixel;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
            s1_flags_reg <= flags_in;
        end
        if (advance && s1_valid_reg)
        begin
            s2_col_reg   <= s1_col_reg;
            s2_row_reg   <= s1_row_reg;
            s2_flags_reg <= s1_flags_reg;
        end
    end

    // upper takes the old lower line, lower takes the new pixel
    ct3_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .wr_en   (advance && s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data ({line_lo, s1_px_reg}),
        .rd_data (line_rd)
    );

    assign line_up = line_rd[LINE_WORD_W-1:PIXEL_W];
    assign line_lo = line_rd[PIXEL_W-1:0];

    ct3_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (advance && s1_valid_reg),
        .up       (line_up),
        .lo       (line_lo),
        .px       (s1_px_reg),
        .code     (census)
    );

    // ---------------- result words ----------------
    always_comb
    begin
        res_a.code        = s2_flags_reg.interior ? census : '0;
        res_a.out_row     = s2_row_reg - ROW_W'(1);
        res_a.out_col     = s2_col_reg - COL_W'(1);
        res_a.is_border   = !s2_flags_reg.interior;
        res_a.frame_done  = 1'b0;
        res_a.last_of_run = !s2_flags_reg.last_col;

        // right border pixel of the row above
        res_b.code        = '0;
        res_b.out_row     = s2_row_reg - ROW_W'(1);
        res_b.out_col     = s2_col_reg;
        res_b.is_border   = 1'b1;
        res_b.frame_done  = s2_flags_reg.last_row;
        res_b.last_of_run = 1'b1;
    end

    assign push_a = advance && s2_valid_reg && s2_flags_reg.emit_a;
    assign push_b = advance && s2_valid_reg && s2_flags_reg.emit_b;

    ct3_out_fifo #(
        .DATA_W ($bits(result_t))
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_a    (push_a),
        .data_a    (res_a),
        .push_b    (push_b),
        .data_b    (res_b),
        .room      (room),
        .out_valid (codes.valid),
        .out_ready (codes.ready),
        .out_data  (res_out)
    );

    assign codes.code        = res_out.code;
    assign codes.out_row     = res_out.out_row;
    assign codes.out_col     = res_out.out_col;
    assign codes.is_border   = res_out.is_border;
    assign codes.frame_done  = res_out.frame_done;
    assign codes.last_of_run = res_out.last_of_run;

    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (COL_W + 1)'(col_reg) < (COL_W + 1)'(width_reg))
        else $error("column counter beyond frame width");

    a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (ROW_W + 1)'(row_reg) < (ROW_W + 1)'(height_reg))
        else $error("row counter beyond frame height");

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> (col_reg == '0) && (row_reg == '0))
        else $error("configuration write did not restart the frame");

    a_accept_staged: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted pixel missing from read stage");

endmodule

// ===== test/census_transform_3x3_tb.sv =====
// Self-checking testbench for the 3x3 census transform: stimulus, prediction and result checks.
`timescale 1ns / 100ps

module census_transform_3x3_tb;
    import ct3_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int MAX_GAP       = 17;
    localparam int SETTLE_CYCLES = 8;
    localparam int RX_HOLD       = 400;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 370;
    localparam int WIDE_ITEMS    = 24;
    localparam int TALL_ITEMS    = 30;
    localparam int ROW_W         = $clog2(MAX_HEIGHT_DEF);
    localparam int COL_W         = $clog2(MAX_WIDTH_DEF);

    // Register slots beyond the defined list; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum int {
        PIX_FULL_RANGE,
        PIX_TIES,
        PIX_EXTREMES
    } pixel_mode_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              border;
        logic              done;
        logic              last;
    } census_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    ct3_pixel_if pix_if ();
    ct3_code_if  code_if ();

    census_transform_3x3 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pixels    (pix_if.sink),
        .codes     (code_if.source)
    );

    // Predictor state
    logic [PIXEL_W-1:0] upper_line [MAX_WIDTH_DEF];
    logic [PIXEL_W-1:0] lower_line [MAX_WIDTH_DEF];
    logic [PIXEL_W-1:0] window [9];
    int unsigned        col_pos    = 0;
    int unsigned        row_pos    = 0;
    int unsigned        width_set  = FRAME_WIDTH_RST;
    int unsigned        height_set = FRAME_HEIGHT_RST;
    census_word_t       pending_codes [$];

    // Run bookkeeping
    int          error_count     = 0;
    int          pixels_accepted = 0;
    int          words_checked   = 0;
    int          frames_closed   = 0;
    int          idle_cycles     = 0;
    int unsigned random_count    = 0;
    bit          tx_idle_on      = 1'b1;
    bit          rx_idle_on      = 1'b1;
    bit          rx_hold_req     = 1'b0;
    pixel_mode_t pixel_mode      = PIX_FULL_RANGE;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic int unsigned clamp_dim(int unsigned value, int unsigned hi);
        if (value < MIN_DIM)
            return MIN_DIM;
        if (value > hi)
            return hi;
        return value;
    endfunction

    task automatic apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_FRAME_WIDTH:
            begin
                width_set = clamp_dim(32'(data[CFG_WIDTH_W-1:0]), MAX_WIDTH_DEF);
                col_pos   = 0;
                row_pos   = 0;
            end
            REG_FRAME_HEIGHT:
            begin
                height_set = clamp_dim(32'(data[CFG_HEIGHT_W-1:0]), MAX_HEIGHT_DEF);
                col_pos    = 0;
                row_pos    = 0;
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic logic [CODE_W-1:0] census_of_window();
        int                neighbour [8] = '{0, 1, 2, 3, 5, 6, 7, 8};
        logic [CODE_W-1:0] bits;
        bits = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (window[neighbour[i]] >= window[4])
                bits[i] = 1'b1;
        end
        return bits;
    endfunction

    task automatic predict_census(logic [PIXEL_W-1:0] px);
        int unsigned        c;
        int unsigned        r;
        int unsigned        w;
        int unsigned        h;
        logic [PIXEL_W-1:0] up;
        logic [PIXEL_W-1:0] lo;
        logic               interior;
        census_word_t       word;
        w = width_set;
        h = height_set;
        c = col_pos;
        r = row_pos;
        if (c >= w)
            c = 0;
        if (r >= h)
            r = 0;
        up = upper_line[c];
        lo = lower_line[c];
        upper_line[c] = lo;
        lower_line[c] = px;
        for (int i = 0; i < 3; i++)
        begin
            window[i*3]   = window[i*3+1];
            window[i*3+1] = window[i*3+2];
        end
        window[2] = up;
        window[5] = lo;
        window[8] = px;
        // The pixel one row up and one column left is now complete
        if (r >= 1 && c >= 1)
        begin
            interior    = (r - 1 >= 1) && (c - 1 >= 1) && (c + 1 <= w);
            word.code   = interior ? census_of_window() : '0;
            word.row    = ROW_W'(r - 1);
            word.col    = COL_W'(c - 1);
            word.border = !interior;
            word.done   = 1'b0;
            word.last   = (c + 1 != w);
            pending_codes.push_back(word);
        end
        // Last column also closes the right border pixel above it
        if (r >= 1 && c + 1 == w)
        begin
            word.code   = '0;
            word.row    = ROW_W'(r - 1);
            word.col    = COL_W'(w - 1);
            word.border = 1'b1;
            word.done   = (r + 1 == h);
            word.last   = 1'b1;
            pending_codes.push_back(word);
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    task automatic report_mismatch(string msg);
        error_count++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic compare_field(string name, int unsigned got, int unsigned want,
                                 census_word_t want_word);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d for pixel row %0d col %0d",
                                      name, got, want, want_word.row, want_word.col));
    endtask

    task automatic check_word();
        census_word_t want;
        if (pending_codes.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word row %0d col %0d code %0h",
                                      code_if.out_row, code_if.out_col, code_if.code));
        end
        else
        begin
            want = pending_codes.pop_front();
            compare_field("code", 32'(code_if.code), 32'(want.code), want);
            compare_field("out_row", 32'(code_if.out_row), 32'(want.row), want);
            compare_field("out_col", 32'(code_if.out_col), 32'(want.col), want);
            compare_field("is_border", 32'(code_if.is_border), 32'(want.border), want);
            compare_field("frame_done", 32'(code_if.frame_done), 32'(want.done), want);
            compare_field("last_of_run", 32'(code_if.last_of_run), 32'(want.last), want);
            if (want.done)
                frames_closed++;
        end
        words_checked++;
    endtask

    // Sample both channels and the register port at the clock edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                apply_reg_write(cfg_index, cfg_wdata);
            if (pix_if.valid && pix_if.ready)
            begin
                predict_census(pix_if.pixel);
                pixels_accepted++;
            end
            if (code_if.valid && code_if.ready)
                check_word();
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (pix_if.valid && pix_if.ready)
            || (code_if.valid && code_if.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no word moved for %0d cycles, %0d codes outstanding",
                         idle_cycles, pending_codes.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Result side: random gaps, plus one long hold on request
    initial
    begin : code_receiver
        int unsigned gap;
        code_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (rx_hold_req)
            begin
                code_if.ready <= 1'b0;
                repeat (RX_HOLD) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            else if (gap != 0)
            begin
                code_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            code_if.ready <= 1'b1;
            @(posedge clk);
            while (!code_if.valid)
                @(posedge clk);
        end
    end

    function automatic logic [PIXEL_W-1:0] draw_pixel();
        case (pixel_mode)
            PIX_TIES:     return PIXEL_W'($urandom_range(0, 3));
            PIX_EXTREMES: return ($urandom_range(0, 1) != 0)
                                 ? PIXEL_W'(255 - $urandom_range(0, 1))
                                 : PIXEL_W'($urandom_range(0, 1));
            default:      return PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Leaves valid high after the handshake so the next word can follow at once
    task automatic send_pixel(logic [PIXEL_W-1:0] px);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0)
        begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= px;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
    endtask

    task automatic send_random_pixels(int unsigned count);
        repeat (count) send_pixel(draw_pixel());
    endtask

    // Drop valid, wait for every pending code, then let the pipeline empty
    task automatic wait_drained();
        pix_if.valid <= 1'b0;
        // let the last accepted pixel reach the predictor first
        @(posedge clk);
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_size();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        pixel_mode = PIX_FULL_RANGE;
        // Reset geometry: codes start once the second row is under way
        send_random_pixels(FRAME_WIDTH_RST + 10);
        wait_drained();
    endtask

    task automatic test_directed();
        logic [PIXEL_W-1:0] corner_frame [12] = '{8'd255, 8'd0,   8'd255, 8'd0,
                                                  8'd0,   8'd255, 8'd0,   8'd128,
                                                  8'd255, 8'd0,   8'd255, 8'd128};
        // Bit 12 lies outside the width field and must be dropped
        write_reg(REG_FRAME_WIDTH, 13'h1004);
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        foreach (corner_frame[i])
            send_pixel(corner_frame[i]);
        wait_drained();
        // Clamp below the minimum, then a flat frame where every neighbour ties
        write_reg(REG_FRAME_WIDTH, 13'd0);
        write_reg(REG_FRAME_HEIGHT, 13'd2);
        repeat (4) send_pixel(8'd7);
        wait_drained();
        // Spare slots must neither change the geometry nor restart the frame
        write_reg(REG_SPARE_A, 13'h1FFF);
        write_reg(REG_SPARE_B, 13'h0000);
        repeat (5) send_pixel(8'd7);
        wait_drained();
    endtask

    task automatic test_restart();
        pixel_mode = PIX_TIES;
        write_reg(REG_FRAME_WIDTH, 13'd6);
        write_reg(REG_FRAME_HEIGHT, 13'd5);
        send_random_pixels(15);
        wait_drained();
        // Abandon the frame part way down and start over
        write_reg(REG_FRAME_HEIGHT, 13'd4);
        send_random_pixels(2 * 6 * 4);
        wait_drained();
    endtask

    task automatic test_backpressure();
        pixel_mode = PIX_FULL_RANGE;
        write_reg(REG_FRAME_WIDTH, 13'd8);
        write_reg(REG_FRAME_HEIGHT, 13'd6);
        tx_idle_on  = 1'b0;
        rx_hold_req = 1'b1;
        send_random_pixels(2 * 8 * 6);
        wait_drained();
        tx_idle_on = 1'b1;
        send_random_pixels(8 * 6);
        wait_drained();
    endtask

    task automatic test_random_frames();
        int unsigned w;
        int unsigned h;
        int unsigned count;
        while (random_count < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                7, 8:    w = $urandom_range(11, 24);
                9:       w = $urandom_range(25, 64);
                default: w = $urandom_range(3, 10);
            endcase
            h = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 12) : $urandom_range(3, 6);
            write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
            write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            pixel_mode = pixel_mode_t'($urandom_range(0, 2));
            count = $urandom_range(1, 3) * w * h;
            // Now and then cut the last frame short
            if ($urandom_range(0, 4) == 0)
                count = count - $urandom_range(1, w * h - 1);
            // Stay within the budget for this test
            if (count > RANDOM_ITEMS - random_count)
                count = RANDOM_ITEMS - random_count;
            send_random_pixels(count);
            random_count += count;
            wait_drained();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_wide_frame();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        pixel_mode = PIX_FULL_RANGE;
        // Both values are clamped: width to its maximum, height to the minimum
        write_reg(REG_FRAME_WIDTH, 13'h0FFF);
        write_reg(REG_FRAME_HEIGHT, 13'd2);
        // Only the start of the first row; nothing is emitted yet
        send_random_pixels(WIDE_ITEMS);
        wait_drained();
    endtask

    task automatic test_tall_frame();
        pixel_mode = PIX_TIES;
        write_reg(REG_FRAME_WIDTH, 13'd3);
        write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
        // First rows of the tallest frame; no frame end may show
        send_random_pixels(TALL_ITEMS);
        wait_drained();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial
    begin
        foreach (window[i])
            window[i] = '0;
        foreach (upper_line[i])
        begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        rst_n        <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= REG_FRAME_WIDTH;
        cfg_wdata    <= '0;
        pix_if.valid <= 1'b0;
        pix_if.pixel <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_size();
        test_directed();
        test_restart();
        test_backpressure();
        test_random_frames();
        test_wide_frame();
        test_tall_frame();

        $display("Run covered %0d pixels and %0d census words across %0d closed frames,",
                 pixels_accepted, words_checked, frames_closed);
        $display("small and reset-sized frames, clamped sizes, restarts and long stalls.");
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
